// ----- sv/sedc_pkg.sv -----
// Shared types and constants for the sorted edge dedup / CSR builder.
// Used by every module of the block; depends on nothing.
package sedc_pkg;

    localparam int unsigned VID_W     = 32;
    localparam int unsigned CNT_W     = 25;
    localparam int unsigned MAX_EDGES = 16777216;
    localparam logic [CNT_W-1:0] MAX_KEPT = CNT_W'(MAX_EDGES);
    localparam int unsigned QDEPTH    = 4;

    typedef enum logic [1:0] {
        ARR_COLUMN  = 2'd0,
        ARR_ROW     = 2'd1,
        ARR_POINTER = 2'd2
    } arr_t;

    typedef struct packed {
        logic [VID_W-1:0] source_vertex;
        logic [VID_W-1:0] dest_vertex;
        logic             final_edge;
    } edge_t;

    typedef struct packed {
        arr_t             target_array;
        logic [CNT_W-1:0] entry_index;
        logic [VID_W-1:0] entry_value;
        logic             order_error;
        logic             end_of_run;
    } result_t;

    // One classified edge: what the back end has to write for it
    typedef struct packed {
        logic [VID_W-1:0] src;
        logic [VID_W-1:0] dst;
        logic [CNT_W-1:0] row_idx;
        logic [CNT_W-1:0] kept;
        logic             do_row;
        logic             do_col;
        logic             do_close;
        logic             err;
    } cmd_t;

endpackage

// ----- sv/sedc_front.sv -----
// Front end: accepts edges, drops duplicates, flags order errors and tracks counts.
// Depends on sedc_pkg; feeds sedc_queue.
module sedc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sedc_pkg::edge_t   s_data,
    output logic              q_push,
    input  logic              q_full,
    output sedc_pkg::cmd_t    q_cmd
);

    logic [sedc_pkg::VID_W-1:0] prev_src_reg, prev_src_next;
    logic [sedc_pkg::VID_W-1:0] prev_dst_reg, prev_dst_next;
    logic                       have_prev_reg, have_prev_next;
    logic [sedc_pkg::CNT_W-1:0] kept_reg, kept_next;
    logic [sedc_pkg::CNT_W-1:0] rows_reg, rows_next;

    logic accept, same_src, dup, err, keep, new_row;

    // hold off the sender while in reset
    assign s_ready = aresetn && !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        same_src = have_prev_reg && (s_data.source_vertex == prev_src_reg);
        dup      = same_src && (s_data.dest_vertex == prev_dst_reg);
        err      = have_prev_reg && ((s_data.source_vertex < prev_src_reg) ||
                   (same_src && (s_data.dest_vertex < prev_dst_reg)));
        keep     = !dup && (kept_reg < sedc_pkg::MAX_KEPT);
        new_row  = keep && !same_src;

        q_cmd.src      = s_data.source_vertex;
        q_cmd.dst      = s_data.dest_vertex;
        q_cmd.row_idx  = rows_reg;
        q_cmd.kept     = kept_reg;
        q_cmd.do_row   = new_row;
        q_cmd.do_col   = keep;
        q_cmd.do_close = s_data.final_edge;
        q_cmd.err      = err;
        // drop edges that write nothing
        q_push = accept && (keep || s_data.final_edge);

        prev_src_next  = prev_src_reg;
        prev_dst_next  = prev_dst_reg;
        have_prev_next = have_prev_reg;
        kept_next      = kept_reg;
        rows_next      = rows_reg;
        if (accept) begin
            if (s_data.final_edge) begin
                prev_src_next  = '0;
                prev_dst_next  = '0;
                have_prev_next = 1'b0;
                kept_next      = '0;
                rows_next      = '0;
            end else begin
                prev_src_next  = s_data.source_vertex;
                prev_dst_next  = s_data.dest_vertex;
                have_prev_next = 1'b1;
                kept_next      = kept_reg + sedc_pkg::CNT_W'(keep);
                rows_next      = rows_reg + sedc_pkg::CNT_W'(new_row);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_src_reg  <= '0;
            prev_dst_reg  <= '0;
            have_prev_reg <= 1'b0;
            kept_reg      <= '0;
            rows_reg      <= '0;
        end else begin
            prev_src_reg  <= prev_src_next;
            prev_dst_reg  <= prev_dst_next;
            have_prev_reg <= have_prev_next;
            kept_reg      <= kept_next;
            rows_reg      <= rows_next;
        end
    end

endmodule

// ----- sv/sedc_queue.sv -----
// Short command queue between front and back end.
// Depends on sedc_pkg for the command type and depth.
module sedc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sedc_pkg::cmd_t  push_cmd,
    output logic            full,
    output logic            q_valid,
    input  logic            pop_ready,
    output sedc_pkg::cmd_t  head_cmd
);

    localparam int unsigned PTR_W = $clog2(sedc_pkg::QDEPTH);
    localparam int unsigned CNT_QW = $clog2(sedc_pkg::QDEPTH + 1);

    sedc_pkg::cmd_t    slots_reg [sedc_pkg::QDEPTH];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              pop;

    assign full     = (count_reg == CNT_QW'(sedc_pkg::QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_cmd = slots_reg[head_reg];
    assign pop      = q_valid && pop_ready;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop) begin
            head_next = (head_reg == PTR_W'(sedc_pkg::QDEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push) begin
            tail_next = (tail_reg == PTR_W'(sedc_pkg::QDEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[tail_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_QW'(sedc_pkg::QDEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with unequal pointers");
`endif

endmodule

// ----- sv/sedc_back.sv -----
// Back end: expands each command into its row, pointer, column and closing words.
// Depends on sedc_pkg; drains sedc_queue and owns the output register.
module sedc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  sedc_pkg::cmd_t    head_cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output sedc_pkg::result_t m_data
);

    sedc_pkg::cmd_t    cur_reg, cur_next;
    logic              cur_valid_reg, cur_valid_next;
    // pending words, bit 0 row, 1 pointer, 2 column, 3 closing pointer
    logic [3:0]        pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    sedc_pkg::result_t out_reg, out_next;

    logic       out_free, emit, last;
    logic [3:0] sel, rest;
    sedc_pkg::result_t word;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        out_free = !out_valid_reg || m_ready;
        emit     = cur_valid_reg && out_free;
        sel      = pend_reg & (~pend_reg + 4'd1);
        rest     = pend_reg & ~sel;
        last     = (rest == 4'd0);
        q_ready  = !cur_valid_reg || (emit && last);

        word.order_error = cur_reg.err;
        word.end_of_run  = last;
        case (sel)
            4'b0001: begin
                word.target_array = sedc_pkg::ARR_ROW;
                word.entry_index  = cur_reg.row_idx;
                word.entry_value  = cur_reg.src;
            end
            4'b0010: begin
                word.target_array = sedc_pkg::ARR_POINTER;
                word.entry_index  = cur_reg.row_idx;
                word.entry_value  = sedc_pkg::VID_W'(cur_reg.kept);
            end
            4'b0100: begin
                word.target_array = sedc_pkg::ARR_COLUMN;
                word.entry_index  = cur_reg.kept;
                word.entry_value  = cur_reg.dst;
            end
            default: begin
                // closing pointer sees the counts after this edge
                word.target_array = sedc_pkg::ARR_POINTER;
                word.entry_index  = cur_reg.row_idx + sedc_pkg::CNT_W'(cur_reg.do_row);
                word.entry_value  = sedc_pkg::VID_W'(cur_reg.kept
                                    + sedc_pkg::CNT_W'(cur_reg.do_col));
            end
        endcase

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free) begin
            out_valid_next = emit;
            out_next       = word;
        end

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        pend_next      = pend_reg;
        if (emit) begin
            pend_next = rest;
            if (last) begin
                cur_valid_next = 1'b0;
            end
        end
        if (q_valid && q_ready) begin
            cur_next       = head_cmd;
            cur_valid_next = 1'b1;
            pend_next      = {head_cmd.do_close, head_cmd.do_col,
                              head_cmd.do_row, head_cmd.do_row};
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_busy_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (pend_reg != 4'd0))
        else $error("active command with nothing pending");
    a_idle_no_work: assert property (@(posedge aclk) disable iff (!aresetn)
        !cur_valid_reg |-> (pend_reg == 4'd0))
        else $error("pending words without a command");
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> $onehot(sel))
        else $error("word select not one-hot");
`endif

endmodule

// ----- sv/sorted_edge_dedup_csr_builder.sv -----
// Channel   Dir  Handshake           Word
// s_        in   s_valid / s_ready   sedc_pkg::edge_t   (source, destination, final flag)
// m_        out  m_valid / m_ready   sedc_pkg::result_t (array, index, value, flags)
//
// An edge is taken every cycle while the four-entry command queue has room; the
// back end writes one word per cycle while m_ready is high, so an edge opening a new
// source writes three words, a further kept edge one, and the final edge one more
// for its closing pointer; its first word passes the queue, command and output registers.
// aresetn is synchronous, active low, and returns the block to the empty-list state.
// A stall on m_ready backs up the queue and then s_ready; non-final duplicates need no back-end slot.
module sorted_edge_dedup_csr_builder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sedc_pkg::edge_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sedc_pkg::result_t m_data
);

    logic           q_push, q_full, q_valid, q_ready;
    sedc_pkg::cmd_t q_cmd, head_cmd;

    sedc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_cmd   (q_cmd)
    );

    sedc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .q_valid   (q_valid),
        .pop_ready (q_ready),
        .head_cmd  (head_cmd)
    );

    sedc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .head_cmd (head_cmd),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sorted_edge_dedup_csr_builder: directed and random edge lists.
// An in-bench CSR write predictor is compared word by word with the result channel.
// Depends on sedc_pkg and the block's top module only.
module tb_top;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 16;
    localparam int MAX_REPORTS    = 10;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    sedc_pkg::edge_t   s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    sedc_pkg::result_t m_data;

    // predictor state
    logic [sedc_pkg::VID_W-1:0] prev_src   = '0;
    logic [sedc_pkg::VID_W-1:0] prev_dst   = '0;
    logic                       prev_valid = 1'b0;
    logic [sedc_pkg::CNT_W-1:0] kept_edges = '0;
    logic [sedc_pkg::CNT_W-1:0] row_fill   = '0;

    sedc_pkg::result_t pending_writes[$];
    int      fail_count = 0;
    int      stall_cycles = 0;
    bit      idle_on = 1'b0;

    sorted_edge_dedup_csr_builder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void predict_csr_writes(sedc_pkg::edge_t e);
        sedc_pkg::result_t w[4];
        int      n;
        logic    same_src;
        logic    dup;
        logic    err;
        n        = 0;
        same_src = prev_valid && (e.source_vertex == prev_src);
        dup      = same_src && (e.dest_vertex == prev_dst);
        err      = prev_valid && ((e.source_vertex < prev_src) ||
                                  (same_src && (e.dest_vertex < prev_dst)));
        if (!dup && (kept_edges < sedc_pkg::MAX_KEPT)) begin
            if (!same_src) begin
                w[n] = '{sedc_pkg::ARR_ROW, row_fill, e.source_vertex, err, 1'b0};
                n++;
                w[n] = '{sedc_pkg::ARR_POINTER, row_fill, 32'(kept_edges), err, 1'b0};
                n++;
                row_fill++;
            end
            w[n] = '{sedc_pkg::ARR_COLUMN, kept_edges, e.dest_vertex, err, 1'b0};
            n++;
            kept_edges++;
        end
        prev_src   = e.source_vertex;
        prev_dst   = e.dest_vertex;
        prev_valid = 1'b1;
        if (e.final_edge) begin
            w[n] = '{sedc_pkg::ARR_POINTER, row_fill, 32'(kept_edges), err, 1'b0};
            n++;
            prev_src   = '0;
            prev_dst   = '0;
            prev_valid = 1'b0;
            kept_edges = '0;
            row_fill   = '0;
        end
        if (n > 0) w[n-1].end_of_run = 1'b1;
        for (int i = 0; i < n; i++) pending_writes.push_back(w[i]);
    endfunction

    function automatic void note_failure(string what, sedc_pkg::result_t want,
                                         sedc_pkg::result_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display({"%0t %s: exp arr=%0d idx=%0d val=%h err=%b eor=%b",
                      " | got arr=%0d idx=%0d val=%h err=%b eor=%b"},
                     $realtime, what, want.target_array, want.entry_index, want.entry_value,
                     want.order_error, want.end_of_run, got.target_array, got.entry_index,
                     got.entry_value, got.order_error, got.end_of_run);
    endfunction

    // check every word taken from the result channel
    always @(posedge aclk) begin
        sedc_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_writes.size() == 0) begin
                note_failure("unexpected word", '0, m_data);
            end else begin
                want = pending_writes.pop_front();
                if (m_data.target_array != want.target_array ||
                    m_data.entry_index  != want.entry_index  ||
                    m_data.entry_value  != want.entry_value  ||
                    m_data.order_error  != want.order_error  ||
                    m_data.end_of_run   != want.end_of_run)
                    note_failure("mismatch", want, m_data);
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= !(idle_on && ($urandom_range(99) < 6));
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_edge(input logic [31:0] src, input logic [31:0] dst, input logic fin);
        sedc_pkg::edge_t e;
        e = '{src, dst, fin};
        while (idle_on && ($urandom_range(99) < 6)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= e;
        do @(posedge aclk); while (!s_ready);
        predict_csr_writes(e);
    endtask

    task automatic wait_drained();
        while (pending_writes.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_edge(32'h0, 32'h0, 1'b0);                 // first edge opens row 0
        send_edge(32'h0, 32'h0, 1'b0);                 // duplicate: dropped
        send_edge(32'h0, 32'hFFFF_FFFF, 1'b0);
        send_edge(32'h0, 32'hFFFF_FFFF, 1'b0);
        send_edge(32'h5, 32'h3, 1'b0);
        send_edge(32'h5, 32'h1, 1'b0);                 // destination out of order
        send_edge(32'h2, 32'h7, 1'b0);                 // source out of order
        send_edge(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_edge(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1); // duplicate final: closing pointer only
        send_edge(32'hAAAA_AAAA, 32'h5555_5555, 1'b1); // single-edge list
        send_edge(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_edge(32'h5555_5555, 32'hAAAA_AAAB, 1'b1); // final on same source
        send_edge(32'h20, 32'h5, 1'b0);
        send_edge(32'h3, 32'h4, 1'b1);                 // out-of-order final
        send_edge(32'h10, 32'h10, 1'b0);
        send_edge(32'h10, 32'h8, 1'b0);
        send_edge(32'h11, 32'h0, 1'b1);
    endtask

    // hold the sender mid-list until every word has drained
    task automatic test_pause_drain();
        for (int k = 0; k < 6; k++) send_edge(32'h100 + k, $urandom, 1'b0);
        s_valid <= 1'b0;
        @(posedge aclk);
        wait_drained();
        send_edge(32'h200, 32'h1, 1'b1);
    endtask

    task automatic test_sorted_lists(input int n_items);
        logic [31:0] src;
        logic [31:0] dst;
        logic [32:0] nxt;
        int          len;
        int          sent;
        int          r;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 24);
            case ($urandom_range(2))
                0:       src = $urandom_range(15);
                1:       src = $urandom;
                default: src = 32'hFFFF_FFFF - $urandom_range(40);
            endcase
            dst = $urandom_range(1) ? $urandom : $urandom_range(7);
            for (int k = 0; k < len; k++) begin
                if (k > 0) begin
                    r = $urandom_range(99);
                    if (r < 8) begin
                        // repeat the previous edge
                    end else if (r < 13) begin
                        if (src != 0 && $urandom_range(1)) src = src - 1;
                        else if (dst != 0) dst = dst - 1;
                        else src = src + 1;
                    end else if (r < 55) begin
                        nxt = {1'b0, dst} + 33'($urandom_range(1, 5));
                        if (!nxt[32]) dst = nxt[31:0];
                    end else begin
                        nxt = {1'b0, src} +
                              33'(($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 4));
                        if (!nxt[32]) src = nxt[31:0];
                        dst = $urandom_range(1) ? $urandom : $urandom_range(7);
                    end
                end
                send_edge(src, dst, k == len - 1);
                sent++;
            end
        end
    endtask

    task automatic test_noise(input int n_items);
        for (int k = 0; k < n_items; k++)
            send_edge($urandom_range(1) ? $urandom : $urandom_range(7),
                      $urandom_range(1) ? $urandom : $urandom_range(7),
                      $urandom_range(9) == 0);
        send_edge($urandom, $urandom, 1'b1);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_pause_drain();
        idle_on = 1'b1;
        test_sorted_lists(180);
        test_noise(60);
        idle_on = 1'b0;
        test_sorted_lists(90);
        idle_on = 1'b1;
        test_sorted_lists(70);
        test_noise(20);
        s_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_writes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/sedc_pkg.sv
sv/sedc_front.sv
sv/sedc_queue.sv
sv/sedc_back.sv
sv/sorted_edge_dedup_csr_builder.sv
dv/tb_top.sv
